@@ src/baro_pressure_temp_compensation_unit_assert.svh @@
// ----------------------------------------------------------------------------
// baro pressure temp compensation unit assertion macros
// concurrent checks with a synchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_UNIT_ASSERT_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BPTC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bptc check failed");

// antecedent implies consequent a fixed number of cycles later
`define BPTC_ASSERT_DELAY(label, clk, rst_n, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error("bptc delayed check failed");

`endif

@@ src/bptc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bptc_pkg
// widths, constants and shared types of the barometer compensation pipeline
// ----------------------------------------------------------------------------
package bptc_pkg;

  localparam int RAW_W   = 24;
  localparam int COEF_W  = 16;
  localparam int PRES_W  = 21;
  localparam int TEMP_W  = 16;
  localparam int IDX_W   = 3;
  localparam int DT_W    = 25;
  localparam int PRD_W   = 42;
  localparam int DTSQ_W  = 50;
  localparam int TMP_W   = 19;
  localparam int SQ_W    = 38;
  localparam int WIDE_W  = 40;
  localparam int LO_W    = 20;
  localparam int PPL_W   = 44;
  localparam int PPH_W   = 45;
  localparam int PROD_W  = 64;
  localparam int Q_W     = 43;
  localparam int DIFF_W  = 44;
  localparam int P_W     = 29;

  localparam logic [RAW_W-1:0] PRES_MIN_RAW = 24'd6056977;
  localparam int TEMP_REF  = 2000;
  localparam int TEMP_LOW  = -1500;
  localparam int PRES_MAX  = 1048575;
  localparam int PRES_MIN  = -1048576;
  localparam int TEMP_MAX  = 32767;
  localparam int TEMP_MIN  = -32768;

  // register stages from accept to result
  localparam int LATENCY = 9;

  typedef enum logic [IDX_W-1:0] {
    CFG_SENS      = 3'd0,
    CFG_OFF       = 3'd1,
    CFG_SENS_TC   = 3'd2,
    CFG_OFF_TC    = 3'd3,
    CFG_REF_TEMP  = 3'd4,
    CFG_TEMP_SENS = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [COEF_W-1:0] sens;
    logic [COEF_W-1:0] off;
    logic [COEF_W-1:0] sens_tc;
    logic [COEF_W-1:0] off_tc;
    logic [COEF_W-1:0] ref_temp;
    logic [COEF_W-1:0] temp_sens;
  } cfg_t;

  typedef struct packed {
    logic                     vld;
    logic                     plaus;
    logic [RAW_W-1:0]         d1;
    logic signed [WIDE_W-1:0] off;
    logic signed [WIDE_W-1:0] sens;
    logic signed [TMP_W-1:0]  temp;
  } comp_t;

endpackage

@@ src/bptc_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bptc_cfg_regs
// calibration coefficient registers behind a plain write port
// ----------------------------------------------------------------------------
module bptc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [bptc_pkg::IDX_W-1:0]  cfg_index,
  input  logic [bptc_pkg::COEF_W-1:0] cfg_data,
  output bptc_pkg::cfg_t              cfg
);
  import bptc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SENS:      cfg_nxt.sens      = cfg_data;
        CFG_OFF:       cfg_nxt.off       = cfg_data;
        CFG_SENS_TC:   cfg_nxt.sens_tc   = cfg_data;
        CFG_OFF_TC:    cfg_nxt.off_tc    = cfg_data;
        CFG_REF_TEMP:  cfg_nxt.ref_temp  = cfg_data;
        CFG_TEMP_SENS: cfg_nxt.temp_sens = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ src/bptc_temp_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bptc_temp_pipe
// dT, first-order offset, sensitivity and temperature, then the
// second-order low temperature corrections; six register stages
// ----------------------------------------------------------------------------
module bptc_temp_pipe (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  logic [bptc_pkg::RAW_W-1:0] in_d1,
  input  logic [bptc_pkg::RAW_W-1:0] in_d2,
  input  bptc_pkg::cfg_t             cfg,
  output bptc_pkg::comp_t            comp
);
  import bptc_pkg::*;

  // stage a: dT and plausibility
  logic                    a_vld_r;
  logic                    a_plaus_r;
  logic [RAW_W-1:0]        a_d1_r;
  logic signed [DT_W-1:0]  a_dt_r;

  // stage b: products with dT
  logic                      b_vld_r;
  logic                      b_plaus_r;
  logic [RAW_W-1:0]          b_d1_r;
  logic signed [PRD_W-1:0]   b_poff_r;
  logic signed [PRD_W-1:0]   b_psens_r;
  logic signed [PRD_W-1:0]   b_ptemp_r;
  logic signed [DTSQ_W-1:0]  b_dtsq_r;

  // stage c: first-order terms
  logic                     c_vld_r;
  logic                     c_plaus_r;
  logic [RAW_W-1:0]         c_d1_r;
  logic signed [WIDE_W-1:0] c_off_r;
  logic signed [WIDE_W-1:0] c_sens_r;
  logic signed [TMP_W-1:0]  c_temp_r;
  logic signed [TMP_W-1:0]  c_dtsq_r;

  // stage d: squares of the temperature distances
  logic                     d_vld_r;
  logic                     d_plaus_r;
  logic [RAW_W-1:0]         d_d1_r;
  logic signed [WIDE_W-1:0] d_off_r;
  logic signed [WIDE_W-1:0] d_sens_r;
  logic signed [TMP_W-1:0]  d_temp_r;
  logic signed [TMP_W-1:0]  d_dtsq_r;
  logic signed [SQ_W-1:0]   d_dsq_r;
  logic signed [SQ_W-1:0]   d_esq_r;
  logic                     d_low_r;
  logic                     d_vlow_r;

  // stage e: correction amounts
  logic                     e_vld_r;
  logic                     e_plaus_r;
  logic [RAW_W-1:0]         e_d1_r;
  logic signed [WIDE_W-1:0] e_off_r;
  logic signed [WIDE_W-1:0] e_sens_r;
  logic signed [TMP_W-1:0]  e_temp_r;
  logic signed [TMP_W-1:0]  e_dtsq_r;
  logic signed [WIDE_W-1:0] e_off_sub1_r;
  logic signed [WIDE_W-1:0] e_off_sub2_r;
  logic signed [WIDE_W-1:0] e_sens_sub1_r;
  logic signed [WIDE_W-1:0] e_sens_sub2_r;
  logic                     e_low_r;

  comp_t comp_r;
  comp_t comp_nxt;

  logic signed [DT_W-1:0]   a_dt_nxt;
  logic signed [PRD_W-1:0]  b_poff_nxt;
  logic signed [PRD_W-1:0]  b_psens_nxt;
  logic signed [PRD_W-1:0]  b_ptemp_nxt;
  logic signed [DTSQ_W-1:0] b_dtsq_nxt;
  logic signed [WIDE_W-1:0] c_off_nxt;
  logic signed [WIDE_W-1:0] c_sens_nxt;
  logic signed [TMP_W-1:0]  c_temp_nxt;
  logic signed [TMP_W-1:0]  c_dtsq_nxt;
  logic signed [TMP_W-1:0]  d_dist_ref;
  logic signed [TMP_W-1:0]  d_dist_low;
  logic signed [SQ_W-1:0]   d_dsq_nxt;
  logic signed [SQ_W-1:0]   d_esq_nxt;
  logic signed [WIDE_W-1:0] e_d5;
  logic signed [WIDE_W-1:0] e_esq;
  logic signed [WIDE_W-1:0] e_e7;
  logic signed [WIDE_W-1:0] e_e11;

  always_comb begin
    a_dt_nxt    = $signed({1'b0, in_d2}) - $signed({1'b0, cfg.ref_temp, 8'd0});
    b_poff_nxt  = $signed({1'b0, cfg.off_tc}) * a_dt_r;
    b_psens_nxt = $signed({1'b0, cfg.sens_tc}) * a_dt_r;
    b_ptemp_nxt = a_dt_r * $signed({1'b0, cfg.temp_sens});
    b_dtsq_nxt  = a_dt_r * a_dt_r;
    c_off_nxt   = $signed({8'd0, cfg.off, 16'd0}) + WIDE_W'(b_poff_r >>> 7);
    c_sens_nxt  = $signed({9'd0, cfg.sens, 15'd0}) + WIDE_W'(b_psens_r >>> 8);
    c_temp_nxt  = TMP_W'(b_ptemp_r >>> 23) + TMP_W'(TEMP_REF);
    c_dtsq_nxt  = TMP_W'(b_dtsq_r >>> 31);
    d_dist_ref  = c_temp_r - TMP_W'(TEMP_REF);
    d_dist_low  = c_temp_r - TMP_W'(TEMP_LOW);
    d_dsq_nxt   = d_dist_ref * d_dist_ref;
    d_esq_nxt   = d_dist_low * d_dist_low;
    e_d5        = (WIDE_W'(d_dsq_r) <<< 2) + WIDE_W'(d_dsq_r);
    e_esq       = WIDE_W'(d_esq_r);
    e_e7        = (e_esq <<< 3) - e_esq;
    e_e11       = (e_esq <<< 3) + (e_esq <<< 1) + e_esq;
    comp_nxt.vld   = e_vld_r;
    comp_nxt.plaus = e_plaus_r;
    comp_nxt.d1    = e_d1_r;
    comp_nxt.off   = e_off_r - e_off_sub1_r - e_off_sub2_r;
    comp_nxt.sens  = e_sens_r - e_sens_sub1_r - e_sens_sub2_r;
    comp_nxt.temp  = e_low_r ? (e_temp_r - e_dtsq_r) : e_temp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
      comp_r.vld <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
      e_vld_r <= d_vld_r;
      comp_r.vld <= comp_nxt.vld;
    end
    comp_r.plaus <= comp_nxt.plaus;
    comp_r.d1    <= comp_nxt.d1;
    comp_r.off   <= comp_nxt.off;
    comp_r.sens  <= comp_nxt.sens;
    comp_r.temp  <= comp_nxt.temp;
  end

  always_ff @(posedge clk) begin
    a_plaus_r <= (in_d1 > PRES_MIN_RAW) && (in_d2 != '0);
    a_d1_r    <= in_d1;
    a_dt_r    <= a_dt_nxt;

    b_plaus_r <= a_plaus_r;
    b_d1_r    <= a_d1_r;
    b_poff_r  <= b_poff_nxt;
    b_psens_r <= b_psens_nxt;
    b_ptemp_r <= b_ptemp_nxt;
    b_dtsq_r  <= b_dtsq_nxt;

    c_plaus_r <= b_plaus_r;
    c_d1_r    <= b_d1_r;
    c_off_r   <= c_off_nxt;
    c_sens_r  <= c_sens_nxt;
    c_temp_r  <= c_temp_nxt;
    c_dtsq_r  <= c_dtsq_nxt;

    d_plaus_r <= c_plaus_r;
    d_d1_r    <= c_d1_r;
    d_off_r   <= c_off_r;
    d_sens_r  <= c_sens_r;
    d_temp_r  <= c_temp_r;
    d_dtsq_r  <= c_dtsq_r;
    d_dsq_r   <= d_dsq_nxt;
    d_esq_r   <= d_esq_nxt;
    d_low_r   <= c_temp_r < TMP_W'(TEMP_REF);
    d_vlow_r  <= c_temp_r < TMP_W'(TEMP_LOW);

    e_plaus_r     <= d_plaus_r;
    e_d1_r        <= d_d1_r;
    e_off_r       <= d_off_r;
    e_sens_r      <= d_sens_r;
    e_temp_r      <= d_temp_r;
    e_dtsq_r      <= d_dtsq_r;
    e_low_r       <= d_low_r;
    e_off_sub1_r  <= d_low_r ? (e_d5 >>> 1) : '0;
    e_sens_sub1_r <= d_low_r ? (e_d5 >>> 2) : '0;
    e_off_sub2_r  <= d_vlow_r ? e_e7 : '0;
    e_sens_sub2_r <= d_vlow_r ? (e_e11 >>> 1) : '0;
  end

  assign comp = comp_r;

endmodule

@@ src/bptc_press_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bptc_press_pipe
// pressure product in two partial products, offset removal, saturation
// and the registered result
// ----------------------------------------------------------------------------
module bptc_press_pipe (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bptc_pkg::comp_t                    comp,
  output logic                               out_strobe,
  output logic signed [bptc_pkg::PRES_W-1:0] out_pressure_pa,
  output logic signed [bptc_pkg::TEMP_W-1:0] out_temp_centi,
  output logic                               out_valid_res
);
  import bptc_pkg::*;

  // stage f: partial products
  logic                     f_vld_r;
  logic                     f_plaus_r;
  logic signed [WIDE_W-1:0] f_off_r;
  logic signed [TMP_W-1:0]  f_temp_r;
  logic [PPL_W-1:0]         f_pp_lo_r;
  logic signed [PPH_W-1:0]  f_pp_hi_r;

  // stage g: full product, scaled
  logic                     g_vld_r;
  logic                     g_plaus_r;
  logic signed [WIDE_W-1:0] g_off_r;
  logic signed [TMP_W-1:0]  g_temp_r;
  logic signed [Q_W-1:0]    g_q_r;

  logic                     strobe_r;
  logic signed [PRES_W-1:0] pressure_r;
  logic signed [TEMP_W-1:0] temp_r;
  logic                     valid_res_r;

  logic [PPL_W-1:0]         f_pp_lo_nxt;
  logic signed [PPH_W-1:0]  f_pp_hi_nxt;
  logic signed [PROD_W-1:0] g_prod;
  logic signed [Q_W-1:0]    g_q_nxt;
  logic signed [DIFF_W-1:0] h_diff;
  logic signed [P_W-1:0]    h_p;
  logic signed [PRES_W-1:0] h_p_sat;
  logic signed [TEMP_W-1:0] h_t_sat;

  always_comb begin
    f_pp_lo_nxt = comp.d1 * comp.sens[LO_W-1:0];
    f_pp_hi_nxt = $signed({1'b0, comp.d1}) * $signed(comp.sens[WIDE_W-1:LO_W]);
    g_prod      = (PROD_W'(f_pp_hi_r) <<< LO_W) + $signed(PROD_W'(f_pp_lo_r));
    g_q_nxt     = Q_W'(g_prod >>> 21);
    h_diff      = DIFF_W'(g_q_r) - DIFF_W'(g_off_r);
    h_p         = P_W'(h_diff >>> 15);
    priority if (h_p > P_W'(PRES_MAX)) begin
      h_p_sat = PRES_W'(PRES_MAX);
    end else if (h_p < P_W'(PRES_MIN)) begin
      h_p_sat = PRES_W'(PRES_MIN);
    end else begin
      h_p_sat = PRES_W'(h_p);
    end
    priority if (g_temp_r > TMP_W'(TEMP_MAX)) begin
      h_t_sat = TEMP_W'(TEMP_MAX);
    end else if (g_temp_r < TMP_W'(TEMP_MIN)) begin
      h_t_sat = TEMP_W'(TEMP_MIN);
    end else begin
      h_t_sat = TEMP_W'(g_temp_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r  <= 1'b0;
      g_vld_r  <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      f_vld_r  <= comp.vld;
      g_vld_r  <= f_vld_r;
      strobe_r <= g_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    f_plaus_r <= comp.plaus;
    f_off_r   <= comp.off;
    f_temp_r  <= comp.temp;
    f_pp_lo_r <= f_pp_lo_nxt;
    f_pp_hi_r <= f_pp_hi_nxt;

    g_plaus_r <= f_plaus_r;
    g_off_r   <= f_off_r;
    g_temp_r  <= f_temp_r;
    g_q_r     <= g_q_nxt;

    pressure_r  <= g_plaus_r ? h_p_sat : '0;
    temp_r      <= g_plaus_r ? h_t_sat : '0;
    valid_res_r <= g_plaus_r;
  end

  assign out_strobe      = strobe_r;
  assign out_pressure_pa = pressure_r;
  assign out_temp_centi  = temp_r;
  assign out_valid_res   = valid_res_r;

endmodule

@@ src/baro_pressure_temp_compensation_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_unit
// Second-order temperature compensation of raw barometer pressure and
// temperature counts. A transaction is taken whenever start is high; busy
// stays low, so one sample pair can enter on every clock. Each result shows
// on the out_ ports for one cycle with out_strobe, in order, and cannot be
// held off. The register stages of the multiplier pipeline hold the products
// with dT, the squares for the low temperature corrections, and the pressure
// product split into two partial products. The user must write coefficients
// on the cfg_ port only while no transaction is in flight; the block itself
// does not enforce this.
// ----------------------------------------------------------------------------
`include "baro_pressure_temp_compensation_unit_assert.svh"

module baro_pressure_temp_compensation_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [bptc_pkg::RAW_W-1:0]         in_raw_pressure,
  input  logic [bptc_pkg::RAW_W-1:0]         in_raw_temperature,
  output logic                               out_strobe,
  output logic signed [bptc_pkg::PRES_W-1:0] out_pressure_pa,
  output logic signed [bptc_pkg::TEMP_W-1:0] out_temp_centi,
  output logic                               out_valid_res,
  input  logic                               cfg_we,
  input  logic [bptc_pkg::IDX_W-1:0]         cfg_index,
  input  logic [bptc_pkg::COEF_W-1:0]        cfg_data
);
  import bptc_pkg::*;

  cfg_t  cfg;
  comp_t comp;

  assign busy = 1'b0;

  bptc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bptc_temp_pipe u_temp_pipe (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (start && !busy),
    .in_d1  (in_raw_pressure),
    .in_d2  (in_raw_temperature),
    .cfg    (cfg),
    .comp   (comp)
  );

  bptc_press_pipe u_press_pipe (
    .clk             (clk),
    .rst_n           (rst_n),
    .comp            (comp),
    .out_strobe      (out_strobe),
    .out_pressure_pa (out_pressure_pa),
    .out_temp_centi  (out_temp_centi),
    .out_valid_res   (out_valid_res)
  );

  // every transaction yields a result after the full pipeline
  `BPTC_ASSERT_DELAY(a_result_latency, clk, rst_n, start && !busy, 9, out_strobe)

  // plausibility of the result follows the raw counts of its transaction
  `BPTC_ASSERT_DELAY(a_valid_tracks_input, clk, rst_n, start && !busy, 9, out_valid_res == $past((in_raw_pressure > PRES_MIN_RAW) && (in_raw_temperature != '0), LATENCY))

  // the temperature stage hands over a result three stages before the output
  `BPTC_ASSERT_DELAY(a_mid_to_out, clk, rst_n, comp.vld, 3, out_strobe)

  // implausible samples report zero values
  `BPTC_ASSERT_IMPL(a_invalid_zero, clk, rst_n, out_strobe && !out_valid_res, out_pressure_pa == '0 && out_temp_centi == '0)

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives raw pressure and temperature pairs into the barometer compensation
// unit under several calibration settings, predicts each compensated reading
// in 64-bit signed arithmetic and checks every strobed result in order.
// ----------------------------------------------------------------------------
module testbench;
  import bptc_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 80;
  localparam int BURST_PHASE  = 5;
  localparam logic [RAW_W-1:0] RAW_TOP = '1;
  localparam int PRES_FLOOR   = 6056977;
  localparam int TEMP_SPREAD  = 1 << 20;

  localparam logic [IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic signed [PRES_W-1:0] pressure;
    logic signed [TEMP_W-1:0] temp;
    logic                     valid;
  } reading_t;

  localparam reading_t REJECTED_READING = '{21'sd0, 16'sd0, 1'b0};
  localparam reading_t UNCALIBRATED_READING = '{21'sd0, 16'sd2000, 1'b1};

  typedef enum {STEP_ITEM, STEP_CFG} step_kind_t;

  typedef struct {
    step_kind_t        kind;
    logic [IDX_W-1:0]  reg_idx;
    logic [COEF_W-1:0] reg_val;
    logic [RAW_W-1:0]  raw_p;
    logic [RAW_W-1:0]  raw_t;
    bit                typed;
    reading_t          want;
  } step_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [RAW_W-1:0]         in_raw_pressure = '0;
  logic [RAW_W-1:0]         in_raw_temperature = '0;
  logic                     out_strobe;
  logic signed [PRES_W-1:0] out_pressure_pa;
  logic signed [TEMP_W-1:0] out_temp_centi;
  logic                     out_valid_res;
  logic                     cfg_we = 1'b0;
  logic [IDX_W-1:0]         cfg_index = '0;
  logic [COEF_W-1:0]        cfg_data = '0;

  cfg_t     coef = '0;
  reading_t pending_readings[$];
  step_t    plan[$];
  int       mismatches = 0;
  int       cycle_count = 0;

  baro_pressure_temp_compensation_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_raw_pressure    (in_raw_pressure),
    .in_raw_temperature (in_raw_temperature),
    .out_strobe         (out_strobe),
    .out_pressure_pa    (out_pressure_pa),
    .out_temp_centi     (out_temp_centi),
    .out_valid_res      (out_valid_res),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic reading_t compensate(input logic [RAW_W-1:0] raw_p,
                                          input logic [RAW_W-1:0] raw_t);
    reading_t r;
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint dt, off, sens, temp, d, prod, p;
    r = REJECTED_READING;
    if (raw_p <= PRES_MIN_RAW || raw_t == '0) begin
      return r;
    end
    d1 = longint'(raw_p);
    d2 = longint'(raw_t);
    c1 = longint'(coef.sens);
    c2 = longint'(coef.off);
    c3 = longint'(coef.sens_tc);
    c4 = longint'(coef.off_tc);
    c5 = longint'(coef.ref_temp);
    c6 = longint'(coef.temp_sens);
    dt = d2 - (c5 << 8);
    prod = c4 * dt;
    off = (c2 << 16) + (prod >>> 7);
    prod = c3 * dt;
    sens = (c1 << 15) + (prod >>> 8);
    prod = dt * c6;
    temp = TEMP_REF + (prod >>> 23);
    if (temp < TEMP_REF) begin
      d = temp - TEMP_REF;
      d = 5 * d * d;
      off = off - (d >>> 1);
      sens = sens - (d >>> 2);
      if (temp < TEMP_LOW) begin
        d = temp - TEMP_LOW;
        d = d * d;
        off = off - 7 * d;
        prod = 11 * d;
        sens = sens - (prod >>> 1);
      end
      prod = dt * dt;
      temp = temp - (prod >>> 31);
    end
    p = d1 * sens;
    p = p >>> 21;
    p = p - off;
    p = p >>> 15;
    if (p > PRES_MAX) p = longint'(PRES_MAX);
    if (p < PRES_MIN) p = longint'(PRES_MIN);
    if (temp > TEMP_MAX) temp = longint'(TEMP_MAX);
    if (temp < TEMP_MIN) temp = longint'(TEMP_MIN);
    r.pressure = p[PRES_W-1:0];
    r.temp = temp[TEMP_W-1:0];
    r.valid = 1'b1;
    return r;
  endfunction

  function automatic logic [COEF_W-1:0] coef_pick();
    int r;
    r = $urandom_range(0, 4);
    case (r)
      0: return '0;
      1: return '1;
      default: return COEF_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic step_t item_step(input logic [RAW_W-1:0] p,
                                      input logic [RAW_W-1:0] t);
    step_t s;
    s.kind = STEP_ITEM;
    s.reg_idx = '0;
    s.reg_val = '0;
    s.raw_p = p;
    s.raw_t = t;
    s.typed = 1'b0;
    s.want = REJECTED_READING;
    return s;
  endfunction

  function automatic step_t known_step(input logic [RAW_W-1:0] p,
                                       input logic [RAW_W-1:0] t,
                                       input reading_t want);
    step_t s;
    s = item_step(p, t);
    s.typed = 1'b1;
    s.want = want;
    return s;
  endfunction

  function automatic step_t reg_step(input logic [IDX_W-1:0] idx,
                                     input logic [COEF_W-1:0] val);
    step_t s;
    s = item_step('0, '0);
    s.kind = STEP_CFG;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_SENS:      coef.sens = val;
      CFG_OFF:       coef.off = val;
      CFG_SENS_TC:   coef.sens_tc = val;
      CFG_OFF_TC:    coef.off_tc = val;
      CFG_REF_TEMP:  coef.ref_temp = val;
      CFG_TEMP_SENS: coef.temp_sens = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // hold the sender off until every reading in flight has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  task automatic sender_gap(input bit burst);
    int r;
    int n;
    n = 0;
    if (!burst) begin
      r = $urandom_range(0, 99);
      if (r >= 90) n = $urandom_range(6, 40);
      else if (r >= 55) n = $urandom_range(1, 3);
    end
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic offer(input logic [RAW_W-1:0] raw_p, input logic [RAW_W-1:0] raw_t,
                       input bit typed, input reading_t want, input bit burst);
    in_raw_pressure <= raw_p;
    in_raw_temperature <= raw_t;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    pending_readings.push_back(typed ? want : compensate(raw_p, raw_t));
    sender_gap(burst);
  endtask

  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_readings.size() == 0) begin
        flag_mismatch("result with no transaction pending", longint'(out_pressure_pa), 0);
      end else begin
        want = pending_readings.pop_front();
        if (out_pressure_pa !== want.pressure)
          flag_mismatch("pressure_pa", longint'(out_pressure_pa), longint'(want.pressure));
        if (out_temp_centi !== want.temp)
          flag_mismatch("temp_centi", longint'(out_temp_centi), longint'(want.temp));
        if (out_valid_res !== want.valid)
          flag_mismatch("valid_res", longint'(out_valid_res), longint'(want.valid));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    step_t            s;
    cfg_t             next;
    logic [RAW_W-1:0] p;
    logic [RAW_W-1:0] t;
    int               r;
    int               t_val;
    bit               burst;

    // uncalibrated: every plausible pair reads 0 Pa at 20.00 C
    plan.push_back(known_step('0, '0, REJECTED_READING));
    plan.push_back(known_step(PRES_MIN_RAW, RAW_TOP, REJECTED_READING));
    plan.push_back(known_step(PRES_MIN_RAW + 24'd1, 24'd1, UNCALIBRATED_READING));
    plan.push_back(known_step(RAW_TOP, '0, REJECTED_READING));
    plan.push_back(known_step(RAW_TOP, RAW_TOP, UNCALIBRATED_READING));
    // typical calibration, spare indexes must be ignored
    plan.push_back(reg_step(CFG_SENS, 16'd40127));
    plan.push_back(reg_step(CFG_OFF, 16'd36924));
    plan.push_back(reg_step(CFG_SENS_TC, 16'd23317));
    plan.push_back(reg_step(CFG_OFF_TC, 16'd23282));
    plan.push_back(reg_step(CFG_REF_TEMP, 16'd33464));
    plan.push_back(reg_step(CFG_TEMP_SENS, 16'd28312));
    plan.push_back(reg_step(CFG_SPARE_LO, 16'hFFFF));
    plan.push_back(reg_step(CFG_SPARE_HI, 16'h1234));
    plan.push_back(item_step(24'd9085466, 24'd8569150));
    plan.push_back(item_step(24'd9085466, 24'd8000000));
    plan.push_back(item_step(24'd9085466, 24'd5000000));
    plan.push_back(item_step(RAW_TOP, 24'd1));
    plan.push_back(item_step(RAW_TOP, RAW_TOP));
    plan.push_back(item_step(PRES_MIN_RAW + 24'd1, 24'd8569150));
    // full-scale calibration drives both outputs into saturation
    plan.push_back(reg_step(CFG_SENS, 16'hFFFF));
    plan.push_back(reg_step(CFG_OFF, 16'hFFFF));
    plan.push_back(reg_step(CFG_SENS_TC, 16'hFFFF));
    plan.push_back(reg_step(CFG_OFF_TC, 16'hFFFF));
    plan.push_back(reg_step(CFG_REF_TEMP, 16'hFFFF));
    plan.push_back(reg_step(CFG_TEMP_SENS, 16'hFFFF));
    plan.push_back(item_step(RAW_TOP, RAW_TOP));
    plan.push_back(item_step(RAW_TOP, 24'd1));
    plan.push_back(item_step(PRES_MIN_RAW + 24'd1, 24'd1));
    plan.push_back(item_step(24'h800000, 24'h800000));
    plan.push_back(known_step('0, RAW_TOP, REJECTED_READING));
    // temperature right at and just under 20.00 C
    plan.push_back(reg_step(CFG_TEMP_SENS, 16'd1));
    plan.push_back(item_step(24'd9085466, 24'd1));
    plan.push_back(item_step(24'd9085466, 24'd16776960));
    plan.push_back(item_step(24'd9085466, 24'd16776959));
    // temperature right at and just under -15.00 C
    plan.push_back(reg_step(CFG_REF_TEMP, 16'h8000));
    plan.push_back(reg_step(CFG_TEMP_SENS, 16'h4000));
    plan.push_back(item_step(24'd9085466, 24'd6596608));
    plan.push_back(item_step(24'd9085466, 24'd6596607));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      s = plan[i];
      if (s.kind == STEP_CFG) begin
        drain();
        write_reg(s.reg_idx, s.reg_val);
      end else begin
        offer(s.raw_p, s.raw_t, s.typed, s.want, 1'b0);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      case (ph)
        0: next = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
        1: next = '0;
        2: next = '1;
        default: next = '{coef_pick(), coef_pick(), coef_pick(), coef_pick(),
                          coef_pick(), coef_pick()};
      endcase
      write_reg(CFG_SENS, next.sens);
      write_reg(CFG_OFF, next.off);
      write_reg(CFG_SENS_TC, next.sens_tc);
      write_reg(CFG_OFF_TC, next.off_tc);
      write_reg(CFG_REF_TEMP, next.ref_temp);
      write_reg(CFG_TEMP_SENS, next.temp_sens);
      if ($urandom_range(0, 1))
        write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, coef_pick());
      burst = (ph == BURST_PHASE);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          p = RAW_W'($urandom_range(0, PRES_FLOOR));
          t = RAW_W'($urandom);
        end else begin
          p = RAW_W'($urandom_range(PRES_FLOOR + 1, RAW_TOP));
          if (r < 6) begin
            t = '0;
          end else if (r < 50) begin
            t = RAW_W'($urandom_range(1, RAW_TOP));
          end else begin
            // around the reference temperature word
            t_val = int'(coef.ref_temp) * 256 + int'($urandom_range(0, 2 * TEMP_SPREAD))
                    - TEMP_SPREAD;
            if (t_val < 1) t_val = 1;
            if (t_val > int'(RAW_TOP)) t_val = int'(RAW_TOP);
            t = t_val[RAW_W-1:0];
          end
        end
        offer(p, t, 1'b0, REJECTED_READING, burst);
      end
    end

    drain();
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
